### hw/rtl/ccks_pkg.sv
// ----------------------------------------------------------------------------
// ChaCha20 keystream XOR: shared definitions
// Constants, configuration codes and types used by the block generator and
// the top level.
// ----------------------------------------------------------------------------
package ccks_pkg;

  // Ten double rounds make the twenty rounds of the cipher.
  localparam int unsigned DOUBLE_ROUNDS = 10;

  // The four fixed words at the head of the state, word 0 in the low lane.
  localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32,
                                        32'h3320646e, 32'h61707865};

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_01    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_23    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_45    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_67    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CTR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_A   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_BC  = 3'd6;

  // Rotate amount of each of the four steps of a quarter round.
  typedef enum logic [1:0] {
    ROT_16,
    ROT_12,
    ROT_8,
    ROT_7
  } ccks_rot_e;

  // Key and nonce words as held by the configuration registers.
  typedef struct packed {
    logic [3:0][63:0] key;
    logic [31:0]      nonce_a;
    logic [63:0]      nonce_bc;
  } ccks_cfg_t;

endpackage

### hw/rtl/chacha20_keystream_xor.sv
// ----------------------------------------------------------------------------
// ChaCha20 keystream XOR
// XORs each data byte with the next ChaCha20 keystream byte; the same block
// encrypts and decrypts. Key, start counter and nonce come from registers.
//
//   Channel  Direction  Handshake               Payload
//   in       sink       in_valid_i / in_ready_o data_byte_i, restart_i,
//                                               final_byte_i
//   out      source     out_valid_o/out_ready_i out_byte_o, last_out_o,
//                                               next_counter_o
//   cfg      sink       cfg_we_i (no wait)      cfg_index_i, cfg_data_i
//
// A byte inside a keystream block is taken from the stored block; a byte
// that opens a block (offset 0 or restart) waits while the rounds and the
// feed-forward add run on the single add/XOR/rotate unit.
// Reset clears the registers, the block counter and the byte offset.
// A result waits in the output register; the next beat is accepted while it
// waits, and the stage behind it holds until the register is free.
// ----------------------------------------------------------------------------
module chacha20_keystream_xor (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                       [7:0] data_byte_i,
  input  logic                             restart_i,
  input  logic                             final_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                       [7:0] out_byte_o,
  output logic                             last_out_o,
  output logic                      [31:0] next_counter_o,
  input  logic                             cfg_we_i,
  input  logic [ccks_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic                      [63:0] cfg_data_i
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_WAIT,
    T_EMIT
  } top_state_e;

  top_state_e          state_q;
  ccks_pkg::ccks_cfg_t cfg_q;
  logic         [31:0] start_ctr_q;
  logic         [31:0] counter_q;
  logic          [5:0] offset_q;
  logic          [7:0] data_q;
  logic                final_q;
  logic                out_valid_q;
  logic          [7:0] out_byte_q;
  logic                last_q;
  logic         [31:0] next_ctr_q;

  logic                accept;
  logic                need_blk;
  logic                gen_start;
  logic         [31:0] blk_ctr;
  logic                gen_done;
  logic          [7:0] ks_byte;
  logic                emit_load;

  // Configuration registers; an unused index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      start_ctr_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ccks_pkg::CFG_KEY_01:    cfg_q.key[0]   <= cfg_data_i;
        ccks_pkg::CFG_KEY_23:    cfg_q.key[1]   <= cfg_data_i;
        ccks_pkg::CFG_KEY_45:    cfg_q.key[2]   <= cfg_data_i;
        ccks_pkg::CFG_KEY_67:    cfg_q.key[3]   <= cfg_data_i;
        ccks_pkg::CFG_START_CTR: start_ctr_q    <= cfg_data_i[31:0];
        ccks_pkg::CFG_NONCE_A:   cfg_q.nonce_a  <= cfg_data_i[31:0];
        ccks_pkg::CFG_NONCE_BC:  cfg_q.nonce_bc <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input beat decode: a restart or offset 0 asks for a new block.
  assign in_ready_o = (state_q == T_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign need_blk   = restart_i || (offset_q == 6'd0);
  assign gen_start  = accept && need_blk;
  assign blk_ctr    = restart_i ? start_ctr_q : counter_q;
  assign emit_load  = (state_q == T_EMIT) && (!out_valid_q || out_ready_i);

  ccks_block_gen u_block_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (gen_start),
    .ctr_i     (blk_ctr),
    .cfg_i     (cfg_q),
    .ks_sel_i  (offset_q),
    .done_o    (gen_done),
    .ks_byte_o (ks_byte)
  );

  // Control sequence and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      counter_q   <= '0;
      offset_q    <= '0;
      data_q      <= '0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      last_q      <= 1'b0;
      next_ctr_q  <= '0;
    end else begin
      // The output register empties when its beat leaves and nothing refills it.
      if (out_ready_i && !emit_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        T_IDLE: begin
          if (accept) begin
            data_q  <= data_byte_i;
            final_q <= final_byte_i;
            if (restart_i) begin
              counter_q <= start_ctr_q;
              offset_q  <= '0;
            end
            state_q <= need_blk ? T_WAIT : T_EMIT;
          end
        end
        T_WAIT: begin
          if (gen_done) begin
            counter_q <= counter_q + 32'd1;
            state_q   <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (emit_load) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= data_q ^ ks_byte;
            last_q      <= final_q;
            next_ctr_q  <= counter_q;
            offset_q    <= offset_q + 6'd1;
            state_q     <= T_IDLE;
          end
        end
        default: begin
          state_q <= T_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign last_out_o     = last_q;
  assign next_counter_o = next_ctr_q;

endmodule

### hw/rtl/ccks_qr_step.sv
// ----------------------------------------------------------------------------
// ChaCha20 keystream XOR: quarter-round step unit
// One add, one XOR and one fixed rotate: p + q, then (r ^ sum) rotated left.
// ----------------------------------------------------------------------------
module ccks_qr_step (
  input  logic                [31:0] p_i,
  input  logic                [31:0] q_i,
  input  logic                [31:0] r_i,
  input  ccks_pkg::ccks_rot_e        rot_i,
  output logic                [31:0] sum_o,
  output logic                [31:0] mix_o
);

  logic [31:0] mixed;

  assign sum_o = p_i + q_i;
  assign mixed = r_i ^ sum_o;

  // Left rotate by the amount of the current step.
  always_comb begin
    case (rot_i)
      ccks_pkg::ROT_16: mix_o = {mixed[15:0], mixed[31:16]};
      ccks_pkg::ROT_12: mix_o = {mixed[19:0], mixed[31:20]};
      ccks_pkg::ROT_8:  mix_o = {mixed[23:0], mixed[31:24]};
      ccks_pkg::ROT_7:  mix_o = {mixed[24:0], mixed[31:25]};
      default:          mix_o = mixed;
    endcase
  end

endmodule

### hw/rtl/ccks_block_gen.sv
// ----------------------------------------------------------------------------
// ChaCha20 keystream XOR: block generator
// Runs the twenty rounds and the feed-forward add on one shared step unit
// and keeps the resulting 64-byte keystream block.
// ----------------------------------------------------------------------------
module ccks_block_gen (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic               [31:0] ctr_i,
  input  ccks_pkg::ccks_cfg_t       cfg_i,
  input  logic                [5:0] ks_sel_i,
  output logic                      done_o,
  output logic                [7:0] ks_byte_o
);

  // The state is kept as four rows of four words (word 4*row + col). The
  // step unit always works on column 0 of each row; the rows are rotated
  // after each quarter round, and skewed around the diagonal half.
  typedef enum logic [2:0] {
    G_IDLE,
    G_ROUND,
    G_SKEW,
    G_UNSKEW,
    G_FEED
  } gen_state_e;

  gen_state_e          state_q;
  logic         [3:0]  cnt_q;
  logic         [3:0]  dr_q;
  logic                diag_q;
  logic        [31:0]  ctr_q;

  logic        [31:0]  x_q    [16];
  logic        [31:0]  x_d    [16];
  logic        [31:0]  upd    [16];
  logic        [31:0]  init_w [16];
  logic        [31:0]  ks_q   [16];

  logic        [31:0]  init_ctr;
  logic        [31:0]  op_p;
  logic        [31:0]  op_q;
  logic        [31:0]  op_r;
  logic        [31:0]  sum;
  logic        [31:0]  mix;
  logic        [31:0]  ks_word;
  ccks_pkg::ccks_rot_e rot;

  // Initial state words; the counter is taken from the start request and
  // held for the feed-forward add.
  always_comb begin
    init_ctr = (state_q == G_IDLE) ? ctr_i : ctr_q;
    for (int i = 0; i < 4; i++) begin
      init_w[i]         = ccks_pkg::SIGMA[i];
      init_w[4 + 2 * i] = cfg_i.key[i][31:0];
      init_w[5 + 2 * i] = cfg_i.key[i][63:32];
    end
    init_w[12] = init_ctr;
    init_w[13] = cfg_i.nonce_a;
    init_w[14] = cfg_i.nonce_bc[31:0];
    init_w[15] = cfg_i.nonce_bc[63:32];
  end

  // Operands: even round steps update a and d, odd round steps c and b.
  always_comb begin
    rot = ccks_pkg::ccks_rot_e'(cnt_q[1:0]);
    if (state_q == G_FEED) begin
      op_p = x_q[0];
      op_q = init_w[cnt_q];
      op_r = x_q[12];
    end else if (cnt_q[0]) begin
      op_p = x_q[8];
      op_q = x_q[12];
      op_r = x_q[4];
    end else begin
      op_p = x_q[0];
      op_q = x_q[4];
      op_r = x_q[12];
    end
  end

  ccks_qr_step u_step (
    .p_i   (op_p),
    .q_i   (op_q),
    .r_i   (op_r),
    .rot_i (rot),
    .sum_o (sum),
    .mix_o (mix)
  );

  // Next working state.
  always_comb begin
    upd = x_q;
    if (cnt_q[0]) begin
      upd[8] = sum;
      upd[4] = mix;
    end else begin
      upd[0]  = sum;
      upd[12] = mix;
    end

    x_d = x_q;
    case (state_q)
      G_IDLE: begin
        if (start_i) begin
          x_d = init_w;
        end
      end
      G_ROUND: begin
        if (cnt_q[1:0] == 2'd3) begin
          // Quarter round done: bring the next column to position 0.
          for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 4; k++) begin
              x_d[4 * r + k] = upd[4 * r + ((k + 1) % 4)];
            end
          end
        end else begin
          x_d = upd;
        end
      end
      G_SKEW: begin
        for (int r = 0; r < 4; r++) begin
          for (int k = 0; k < 4; k++) begin
            x_d[4 * r + k] = x_q[4 * r + ((k + r) % 4)];
          end
        end
      end
      G_UNSKEW: begin
        for (int r = 0; r < 4; r++) begin
          for (int k = 0; k < 4; k++) begin
            x_d[4 * r + k] = x_q[4 * r + ((k + 4 - r) % 4)];
          end
        end
      end
      G_FEED: begin
        // Turn the whole state as one ring so word j reaches position 0.
        for (int i = 0; i < 16; i++) begin
          x_d[i] = x_q[(i + 1) % 16];
        end
      end
      default: begin
        x_d = x_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  // Keystream block, one word written per feed-forward cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == G_FEED) begin
      ks_q[cnt_q] <= sum;
    end
  end

  // Sequencer: column half, skew, diagonal half, unskew, ten times over,
  // then the feed-forward pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      cnt_q   <= '0;
      dr_q    <= '0;
      diag_q  <= 1'b0;
      ctr_q   <= '0;
    end else begin
      case (state_q)
        G_IDLE: begin
          if (start_i) begin
            state_q <= G_ROUND;
            cnt_q   <= '0;
            dr_q    <= '0;
            diag_q  <= 1'b0;
            ctr_q   <= ctr_i;
          end
        end
        G_ROUND: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            state_q <= diag_q ? G_UNSKEW : G_SKEW;
          end
        end
        G_SKEW: begin
          diag_q  <= 1'b1;
          state_q <= G_ROUND;
        end
        G_UNSKEW: begin
          diag_q <= 1'b0;
          if (dr_q == 4'(ccks_pkg::DOUBLE_ROUNDS - 1)) begin
            state_q <= G_FEED;
          end else begin
            dr_q    <= dr_q + 4'd1;
            state_q <= G_ROUND;
          end
        end
        G_FEED: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            state_q <= G_IDLE;
          end
        end
        default: begin
          state_q <= G_IDLE;
        end
      endcase
    end
  end

  assign done_o = (state_q == G_FEED) && (cnt_q == 4'd15);

  // Byte read from the stored block, little-endian within each word.
  assign ks_word   = ks_q[ks_sel_i[5:2]];
  assign ks_byte_o = ks_word[{ks_sel_i[1:0], 3'b000} +: 8];

endmodule

### hw/rtl/ccks_checker.sv
// ----------------------------------------------------------------------------
// ChaCha20 keystream XOR: port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module ccks_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic  [7:0] data_byte_i,
  input logic        restart_i,
  input logic        final_byte_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic  [7:0] out_byte_o,
  input logic        last_out_o,
  input logic [31:0] next_counter_o
);

  // A stalled result beat stays and keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
      $stable(last_out_o) && $stable(next_counter_o))
    else $error("result beat changed while stalled");

  // A waiting input beat stays and keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(data_byte_i) &&
      $stable(restart_i) && $stable(final_byte_i))
    else $error("input beat changed while waiting");

  // Each input beat is worked on alone: ready drops right after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // A new result comes only out of a busy cycle, never from idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while the block was idle");

endmodule

bind chacha20_keystream_xor ccks_checker u_ccks_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .data_byte_i    (data_byte_i),
  .restart_i      (restart_i),
  .final_byte_i   (final_byte_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_byte_o     (out_byte_o),
  .last_out_o     (last_out_o),
  .next_counter_o (next_counter_o)
);

### verif/chacha20_keystream_xor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 keystream XOR testbench
// Drives byte beats through the cipher and compares every output beat with
// a local ChaCha20 keystream predictor. The predictor keeps its own key,
// nonce, counter and offset. The stimulus starts with directed beats: reset
// registers, all-ones registers, counter wrap, mid-block restart and a
// register change in mid-block. After that come random message streams
// under several register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module chacha20_keystream_xor_tb;

  localparam int unsigned IDLE_PCT      = 19;
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned HOLD_AT       = 600;
  localparam int unsigned HOLD_CYCLES   = 2000;
  localparam int unsigned CYCLE_LIMIT   = 4000000;
  localparam int unsigned RAND_PHASES   = 8;
  localparam int unsigned PHASE_BEATS   = 170;
  localparam int unsigned MAX_REPORTS   = 50;

  typedef logic [ccks_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  // Index with no register behind it; writes to it must be ignored.
  localparam cfg_idx_t CFG_UNUSED = 3'd7;

  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ZEROS,
    FILL_ONES
  } fill_e;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       fin;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_out;
    logic [31:0] ctr;
  } out_beat_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_ready_o;
  logic [7:0]           data_byte_i    = '0;
  logic                 restart_i      = 1'b0;
  logic                 final_byte_i   = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i    = 1'b0;
  logic [7:0]           out_byte_o;
  logic                 last_out_o;
  logic [31:0]          next_counter_o;
  logic                 cfg_we_i       = 1'b0;
  cfg_idx_t             cfg_index_i    = '0;
  logic [63:0]          cfg_data_i     = '0;

  // Register shadows and keystream state of the predictor.
  logic [3:0][63:0]     key_sh;
  logic [31:0]          start_ctr_sh;
  logic [31:0]          nonce_a_sh;
  logic [63:0]          nonce_bc_sh;
  logic [31:0]          ctr_m;
  logic [5:0]           offset_m;
  logic [15:0][31:0]    ks_m;

  in_beat_t             byte_q[$];
  out_beat_t            cipher_q[$];

  bit                   steady     = 1'b0;
  bit                   held       = 1'b0;
  int unsigned          hold_left  = 0;
  int unsigned          err_cnt    = 0;
  int unsigned          push_cnt   = 0;
  int unsigned          sent_cnt   = 0;
  int unsigned          rx_cnt     = 0;
  int unsigned          block_cnt  = 0;
  int unsigned          restart_cnt = 0;
  int unsigned          wrap_cnt   = 0;
  int unsigned          setting_cnt = 0;
  int unsigned          cycle_cnt  = 0;

  chacha20_keystream_xor u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .restart_i      (restart_i),
    .final_byte_i   (final_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_out_o     (last_out_o),
    .next_counter_o (next_counter_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Run limit in case the block hangs.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Run limit of %0d cycles reached with %0d beats outstanding.",
               CYCLE_LIMIT, cipher_q.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] rotl32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [15:0][31:0] quarter(logic [15:0][31:0] x,
                                                 int a, int b, int c, int d);
    x[a] = x[a] + x[b]; x[d] = rotl32(x[d] ^ x[a], 16);
    x[c] = x[c] + x[d]; x[b] = rotl32(x[b] ^ x[c], 12);
    x[a] = x[a] + x[b]; x[d] = rotl32(x[d] ^ x[a], 8);
    x[c] = x[c] + x[d]; x[b] = rotl32(x[b] ^ x[c], 7);
    return x;
  endfunction

  // One 64-byte keystream block for the given counter and current shadows.
  function automatic logic [15:0][31:0] keystream_block(logic [31:0] ctr);
    logic [15:0][31:0] init;
    logic [15:0][31:0] x;
    int i;
    for (i = 0; i < 4; i++) begin
      init[i]         = ccks_pkg::SIGMA[i];
      init[4 + 2 * i] = key_sh[i][31:0];
      init[5 + 2 * i] = key_sh[i][63:32];
    end
    init[12] = ctr;
    init[13] = nonce_a_sh;
    init[14] = nonce_bc_sh[31:0];
    init[15] = nonce_bc_sh[63:32];
    x = init;
    for (i = 0; i < ccks_pkg::DOUBLE_ROUNDS; i++) begin
      x = quarter(x, 0, 4, 8, 12);
      x = quarter(x, 1, 5, 9, 13);
      x = quarter(x, 2, 6, 10, 14);
      x = quarter(x, 3, 7, 11, 15);
      x = quarter(x, 0, 5, 10, 15);
      x = quarter(x, 1, 6, 11, 12);
      x = quarter(x, 2, 7, 8, 13);
      x = quarter(x, 3, 4, 9, 14);
    end
    for (i = 0; i < 16; i++) x[i] = x[i] + init[i];
    return x;
  endfunction

  // Advances the predicted keystream by one byte and queues the output beat.
  task automatic xor_next_byte(in_beat_t b);
    out_beat_t   e;
    logic [31:0] word;
    if (b.restart) begin
      ctr_m    = start_ctr_sh;
      offset_m = '0;
      restart_cnt++;
    end
    if (offset_m == '0) begin
      ks_m  = keystream_block(ctr_m);
      ctr_m = ctr_m + 32'd1;
      block_cnt++;
      if (ctr_m == '0) wrap_cnt++;
    end
    word       = ks_m[offset_m[5:2]];
    e.out_byte = b.data ^ word[{offset_m[1:0], 3'b000} +: 8];
    e.last_out = b.fin;
    e.ctr      = ctr_m;
    offset_m   = offset_m + 6'd1;
    cipher_q.push_back(e);
  endtask

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("MISMATCH at output beat %0d: %s got %h, expected %h",
               rx_cnt, field, got, want);
  endtask

  function automatic void push_beat(logic [7:0] d, bit rs, bit fn);
    in_beat_t b;
    b.data    = d;
    b.restart = rs;
    b.fin     = fn;
    byte_q.push_back(b);
    push_cnt++;
  endfunction

  // One register write per clock; the shadow follows at once since the
  // block is idle.
  task automatic cfg_write(cfg_idx_t idx, logic [63:0] d);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    case (idx)
      ccks_pkg::CFG_KEY_01:    key_sh[0]    = d;
      ccks_pkg::CFG_KEY_23:    key_sh[1]    = d;
      ccks_pkg::CFG_KEY_45:    key_sh[2]    = d;
      ccks_pkg::CFG_KEY_67:    key_sh[3]    = d;
      ccks_pkg::CFG_START_CTR: start_ctr_sh = d[31:0];
      ccks_pkg::CFG_NONCE_A:   nonce_a_sh   = d[31:0];
      ccks_pkg::CFG_NONCE_BC:  nonce_bc_sh  = d;
      default: ;
    endcase
  endtask

  // Writes the registers selected by mask after the block has settled.
  task automatic load_regs(logic [6:0] mask, fill_e fill, bit poke_unused);
    logic [63:0] v;
    int i;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (i = 0; i < 7; i++) begin
      if (mask[i]) begin
        case (fill)
          FILL_ZEROS: v = '0;
          FILL_ONES:  v = '1;
          default:    v = {$urandom, $urandom};
        endcase
        // Start near the top so the counter wraps within a few blocks.
        if (i == ccks_pkg::CFG_START_CTR && fill == FILL_RANDOM && $urandom_range(1))
          v[31:0] = 32'hFFFF_FFFF - $urandom_range(3);
        cfg_write(cfg_idx_t'(i), v);
      end
    end
    if (poke_unused) cfg_write(CFG_UNUSED, {$urandom, $urandom});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    setting_cnt++;
  endtask

  // Waits until every queued beat has come back as a result.
  task automatic wait_drained();
    while (rx_cnt != push_cnt)
      @(posedge clk_i);
  endtask

  // Input driver: offers queued beats, with random gaps between them.
  always @(posedge clk_i) begin : in_driver
    in_beat_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        nxt.data    = data_byte_i;
        nxt.restart = restart_i;
        nxt.fin     = final_byte_i;
        xor_next_byte(nxt);
        sent_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (byte_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          nxt           = byte_q.pop_front();
          data_byte_i  <= nxt.data;
          restart_i    <= nxt.restart;
          final_byte_i <= nxt.fin;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each beat and stalls at random, once for long.
  always @(posedge clk_i) begin : out_monitor
    out_beat_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (cipher_q.size() == 0) begin
          report_mismatch("beat with nothing expected", {24'd0, out_byte_o}, '0);
        end else begin
          want = cipher_q.pop_front();
          if (out_byte_o !== want.out_byte)
            report_mismatch("out_byte", {24'd0, out_byte_o}, {24'd0, want.out_byte});
          if (last_out_o !== want.last_out)
            report_mismatch("last_out", {31'd0, last_out_o}, {31'd0, want.last_out});
          if (next_counter_o !== want.ctr)
            report_mismatch("next_counter", next_counter_o, want.ctr);
        end
        rx_cnt++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!held && rx_cnt >= HOLD_AT) begin
        held        = 1'b1;
        hold_left   = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Stimulus: directed phases first, then random message streams.
  initial begin
    int p;
    int n;
    int k;
    int len;
    bit rs;
    fill_e fill;
    logic [6:0] mask;

    key_sh       = '0;
    start_ctr_sh = '0;
    nonce_a_sh   = '0;
    nonce_bc_sh  = '0;
    ctr_m        = '0;
    offset_m     = '0;
    ks_m         = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers; the stream starts without a restart.
    push_beat(8'h00, 1'b0, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b0);
    push_beat(8'hA5, 1'b0, 1'b1);
    push_beat(8'h5A, 1'b1, 1'b0);
    push_beat(8'h00, 1'b0, 1'b1);
    wait_drained();

    // All ones, with the start counter at the top so the first block wraps.
    load_regs(7'h7F, FILL_ONES, 1'b1);
    push_beat(8'hFF, 1'b1, 1'b0);
    push_beat(8'h00, 1'b0, 1'b0);
    push_beat(8'h80, 1'b0, 1'b0);
    push_beat(8'h01, 1'b1, 1'b0);
    push_beat(8'h7F, 1'b0, 1'b1);
    push_beat(8'hFF, 1'b1, 1'b1);
    wait_drained();

    // New key in mid-block: the old block runs on until the next one.
    load_regs(7'h1F, FILL_ZEROS, 1'b0);
    push_beat(8'h3C, 1'b0, 1'b0);
    push_beat(8'hC3, 1'b0, 1'b1);
    push_beat(8'h96, 1'b1, 1'b0);
    push_beat(8'h69, 1'b0, 1'b1);
    wait_drained();

    // Random messages: mostly framed streams, some stray beats.
    for (p = 0; p < RAND_PHASES; p++) begin
      case (p)
        1:       fill = FILL_ZEROS;
        2:       fill = FILL_ONES;
        default: fill = FILL_RANDOM;
      endcase
      mask = (p < 3) ? 7'h7F : 7'($urandom);
      load_regs(mask, fill, $urandom_range(3) == 0);
      steady <= (p == 4);
      n = 0;
      while (n < PHASE_BEATS) begin
        if ($urandom_range(9) == 0) begin
          push_beat(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
          n++;
        end else begin
          len = ($urandom_range(3) == 0) ? $urandom_range(200, 64) : $urandom_range(40, 1);
          rs  = $urandom_range(9) < 8;
          for (k = 0; k < len; k++)
            push_beat(8'($urandom), rs && k == 0, k == len - 1);
          n += len;
        end
      end
      wait_drained();
      steady <= 1'b0;
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d beats and checked %0d, over %0d keystream blocks and %0d restarts.",
             sent_cnt, rx_cnt, block_cnt, restart_cnt);
    $display("Saw %0d counter wraps under %0d register settings.", wrap_cnt, setting_cnt);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches found.", err_cnt);
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/ccks_pkg.sv
hw/rtl/ccks_qr_step.sv
hw/rtl/ccks_block_gen.sv
hw/rtl/chacha20_keystream_xor.sv
hw/rtl/ccks_checker.sv
verif/chacha20_keystream_xor_tb.sv
